@@ sv/fcfs_pkg.sv @@
// package: item types, widths and saturating helpers for the fcfs scheduler
`default_nettype none
package fcfs_pkg;

  localparam int TIME_W = 24;
  localparam int SUM_W  = 30;
  localparam int FLD_W  = 16;
  localparam int IDX_W  = 6;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef struct packed {
    logic [FLD_W-1:0] arrival;
    logic [FLD_W-1:0] burst;
    logic             final_process;
  } fcfs_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  proc_index;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [SUM_W-1:0]  sum_turnaround;
    logic [SUM_W-1:0]  sum_waiting;
    logic              batch_end;
  } fcfs_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_PICK,
    ST_EMIT_RD,
    ST_EMIT_WR
  } fcfs_state_t;

  function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] a,
                                                 input logic [FLD_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - FLD_W){1'b0}}, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] a,
                                               input logic [TIME_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - TIME_W){1'b0}}, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/fcfs_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module fcfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/fcfs_schedule_times.sv @@
// First-come-first-served batch scheduler.
// The proc channel loads one process (arrival, burst) per item into a table,
// one item per cycle while proc_stall is low, in load order. Items beyond MAX_PROCESSES are dropped.
// The item with final_process set is loaded too and starts scheduling; proc_stall
// is then high until the batch has been handed to the output register.
// Scheduling makes N picks for a batch of N; each pick streams the table out of
// the arrival/burst ram, one entry a cycle, waits for the read to drain, then
// updates time and writes the finish ram; the single read port of the table ram
// sets this one-entry-a-cycle pace.
// Results then leave on the res channel in load order, each through a ram read
// and then an output load, carrying running turnaround and waiting totals;
// batch_end marks the last. A stall on res holds the output register and the
// result sequence; the next batch can start loading while the last result waits.
// Reset (synchronous, active high) empties the batch, clears times and totals
// and the done flags; table contents are not cleared and need not be.
`default_nettype none
module fcfs_schedule_times #(
  parameter int MAX_PROCESSES = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                proc_valid,
  output logic                     proc_stall,
  input  wire fcfs_pkg::fcfs_in_t  proc,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output fcfs_pkg::fcfs_out_t      res
);
  import fcfs_pkg::*;

  localparam int AW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PROCESSES);

  fcfs_state_t state, state_next;

  logic [CW-1:0]     count;
  logic [CW-1:0]     scan_idx;
  logic [CW-1:0]     pick_cnt;
  logic              rd_vld;
  logic [AW-1:0]     rd_idx;
  logic              best_found;
  logic [FLD_W-1:0]  best_arr;
  logic [FLD_W-1:0]  best_burst;
  logic [AW-1:0]     best_idx;
  logic [TIME_W-1:0] cur_time;
  logic [SUM_W-1:0]  sum_tat;
  logic [SUM_W-1:0]  sum_wt;
  logic [MAX_PROCESSES-1:0] done;

  logic [2*FLD_W-1:0] tbl_rdata;
  logic [TIME_W-1:0]  fin_rdata;

  // control decode
  logic              in_take;
  logic              tbl_we;
  logic              fin_we;
  logic              scan_issue;
  logic              emit_load;
  logic              batch_clear;
  logic              pick_last;
  logic              emit_last;

  // datapath values
  logic [FLD_W-1:0]  rd_arr;
  logic [FLD_W-1:0]  rd_burst;
  logic [TIME_W-1:0] pick_start;
  logic [TIME_W-1:0] pick_finish;
  logic [TIME_W-1:0] tat;
  logic [TIME_W-1:0] wt;
  logic [SUM_W-1:0]  sum_tat_next;
  logic [SUM_W-1:0]  sum_wt_next;

  assign rd_arr   = tbl_rdata[2*FLD_W-1:FLD_W];
  assign rd_burst = tbl_rdata[FLD_W-1:0];

  assign pick_last = (pick_cnt + CW'(1)) == count;
  assign emit_last = (scan_idx + CW'(1)) == count;

  fcfs_ram #(.WIDTH(2 * FLD_W), .DEPTH(MAX_PROCESSES), .AW(AW)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (count[AW-1:0]),
    .wdata ({proc.arrival, proc.burst}),
    .raddr (scan_idx[AW-1:0]),
    .rdata (tbl_rdata)
  );

  fcfs_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCESSES), .AW(AW)) u_fin_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (best_idx),
    .wdata (pick_finish),
    .raddr (scan_idx[AW-1:0]),
    .rdata (fin_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (proc_valid && proc.final_process) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == count && !rd_vld) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        state_next = pick_last ? ST_EMIT_RD : ST_SCAN;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (!res_valid || !res_stall) begin
          state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // outputs and strobes
  always_comb begin
    proc_stall  = 1'b1;
    in_take     = 1'b0;
    tbl_we      = 1'b0;
    fin_we      = 1'b0;
    scan_issue  = 1'b0;
    emit_load   = 1'b0;
    batch_clear = 1'b0;
    unique case (state)
      ST_LOAD: begin
        proc_stall = 1'b0;
        in_take    = proc_valid;
        tbl_we     = proc_valid && (count < CNT_MAX);
      end
      ST_SCAN: begin
        scan_issue = scan_idx < count;
      end
      ST_PICK: begin
        fin_we = 1'b1;
      end
      ST_EMIT_RD: begin
      end
      ST_EMIT_WR: begin
        emit_load   = !res_valid || !res_stall;
        batch_clear = emit_load && emit_last;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pick_start  = (cur_time < TIME_W'(best_arr)) ? TIME_W'(best_arr) : cur_time;
    pick_finish = time_add(pick_start, best_burst);
  end

  always_comb begin
    tat          = (fin_rdata > TIME_W'(rd_arr)) ? fin_rdata - TIME_W'(rd_arr) : '0;
    wt           = (tat > TIME_W'(rd_burst)) ? tat - TIME_W'(rd_burst) : '0;
    sum_tat_next = sum_add(sum_tat, tat);
    sum_wt_next  = sum_add(sum_wt, wt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      scan_idx   <= '0;
      pick_cnt   <= '0;
      rd_vld     <= 1'b0;
      best_found <= 1'b0;
      cur_time   <= '0;
      sum_tat    <= '0;
      sum_wt     <= '0;
      done       <= '0;
      res_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= scan_issue;

      if (tbl_we) begin
        count <= count + CW'(1);
      end
      if (in_take && proc.final_process) begin
        scan_idx   <= '0;
        pick_cnt   <= '0;
        best_found <= 1'b0;
      end

      if (scan_issue) begin
        scan_idx <= scan_idx + CW'(1);
      end
      // ties keep the lower index, so only a strictly earlier arrival wins
      if (rd_vld && !done[rd_idx] && (!best_found || rd_arr < best_arr)) begin
        best_found <= 1'b1;
      end

      if (state == ST_PICK) begin
        cur_time       <= pick_finish;
        done[best_idx] <= 1'b1;
        pick_cnt       <= pick_cnt + CW'(1);
        best_found     <= 1'b0;
        scan_idx       <= '0;
      end

      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (emit_load) begin
        res_valid <= 1'b1;
        sum_tat   <= sum_tat_next;
        sum_wt    <= sum_wt_next;
        scan_idx  <= scan_idx + CW'(1);
      end

      if (batch_clear) begin
        count    <= '0;
        cur_time <= '0;
        sum_tat  <= '0;
        sum_wt   <= '0;
        done     <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= scan_idx[AW-1:0];
    if (rd_vld && !done[rd_idx] && (!best_found || rd_arr < best_arr)) begin
      best_arr   <= rd_arr;
      best_burst <= rd_burst;
      best_idx   <= rd_idx;
    end
    if (emit_load) begin
      res.proc_index     <= IDX_W'(scan_idx);
      res.completion     <= fin_rdata;
      res.turnaround     <= tat;
      res.waiting        <= wt;
      res.sum_turnaround <= sum_tat_next;
      res.sum_waiting    <= sum_wt_next;
      res.batch_end      <= emit_last;
    end
  end

  // every pick must have found an unfinished process
  a_pick_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_PICK |-> best_found)
    else $error("pick without a candidate");

  a_pick_marks_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_PICK |=> done[$past(best_idx)] || $past(batch_clear))
    else $error("picked process not marked done");

  a_pick_bound: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> pick_cnt <= count)
    else $error("more picks than processes");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("process count beyond table depth");

  a_last_result_idle: assert property (@(posedge clk) disable iff (rst)
    batch_clear |=> state == ST_LOAD && count == '0)
    else $error("batch not cleared after last result");

endmodule
`default_nettype wire
